### src/nmea_chk_pkg.sv
// shared types, codes and lookup functions for the nmea sentence checker
package nmea_chk_pkg;

   // saturation point of the field counter
   localparam int unsigned FIELD_COUNT_LIMIT = 63;
   localparam int unsigned CNT_W = $clog2(FIELD_COUNT_LIMIT + 1);

   // width of the reported field count and the largest value it shows
   localparam int unsigned FIELD_OUT_W    = 6;
   localparam int unsigned FIELD_SHOW_MAX =
      (FIELD_COUNT_LIMIT < 63) ? FIELD_COUNT_LIMIT : 63;

   // number of characters in the unicore heading prefix
   localparam logic [3:0] UNI_PREFIX_LEN = 4'd13;

   // minimum field counts per sentence type
   localparam logic [CNT_W-1:0] NEED_GGA = CNT_W'(12);
   localparam logic [CNT_W-1:0] NEED_RMC = CNT_W'(9);
   localparam logic [CNT_W-1:0] NEED_THS = CNT_W'(3);
   localparam logic [CNT_W-1:0] NEED_HPR = CNT_W'(9);
   localparam logic [CNT_W-1:0] NEED_UNI = CNT_W'(10);

   // ascii characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // reject reasons
   localparam logic [2:0] RSN_OK       = 3'd0;
   localparam logic [2:0] RSN_FRAME    = 3'd1;
   localparam logic [2:0] RSN_CHECKSUM = 3'd2;
   localparam logic [2:0] RSN_TALKER   = 3'd3;
   localparam logic [2:0] RSN_HEADER   = 3'd4;
   localparam logic [2:0] RSN_FIELDS   = 3'd5;

   // sentence kinds
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_GGA  = 3'd1;
   localparam logic [2:0] KIND_RMC  = 3'd2;
   localparam logic [2:0] KIND_THS  = 3'd3;
   localparam logic [2:0] KIND_HPR  = 3'd4;
   localparam logic [2:0] KIND_UNI  = 3'd5;

   // talker codes
   localparam logic [3:0] TALK_NONE = 4'd0;
   localparam logic [3:0] TALK_GP   = 4'd1;
   localparam logic [3:0] TALK_GN   = 4'd2;
   localparam logic [3:0] TALK_GL   = 4'd3;
   localparam logic [3:0] TALK_GA   = 4'd4;
   localparam logic [3:0] TALK_GB   = 4'd5;
   localparam logic [3:0] TALK_BD   = 4'd6;
   localparam logic [3:0] TALK_GQ   = 4'd7;
   localparam logic [3:0] TALK_IN   = 4'd8;
   localparam logic [3:0] TALK_UN   = 4'd9;

   // parser phase, one-hot
   typedef enum logic [13:0] {
      PH_WAIT      = 14'b00000000000001,
      PH_D_HEAD    = 14'b00000000000010,
      PH_D_BODY    = 14'b00000000000100,
      PH_D_HEX1    = 14'b00000000001000,
      PH_D_HEX2    = 14'b00000000010000,
      PH_D_OK      = 14'b00000000100000,
      PH_D_BADHEX  = 14'b00000001000000,
      PH_U_PREFIX  = 14'b00000010000000,
      PH_U_SEMI    = 14'b00000100000000,
      PH_U_PAY     = 14'b00001000000000,
      PH_U_DONE    = 14'b00010000000000,
      PH_FRAME     = 14'b00100000000000,
      PH_U_BADPFX  = 14'b01000000000000,
      PH_D_BADSUM  = 14'b10000000000000
   } phase_type;

   // hex digit value, bit 4 set for a non-hex character
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
      else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
      else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
      else v = 5'd16;
      return v;
   endfunction

   // character of "#UNIHEADINGA," at a position
   function automatic logic [7:0] uni_prefix_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h23; // #
         4'd1:    c = 8'h55; // U
         4'd2:    c = 8'h4E; // N
         4'd3:    c = 8'h49; // I
         4'd4:    c = 8'h48; // H
         4'd5:    c = 8'h45; // E
         4'd6:    c = 8'h41; // A
         4'd7:    c = 8'h44; // D
         4'd8:    c = 8'h49; // I
         4'd9:    c = 8'h4E; // N
         4'd10:   c = 8'h47; // G
         4'd11:   c = 8'h41; // A
         4'd12:   c = 8'h2C; // ,
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // talker code of a two-letter prefix, none when not listed
   function automatic logic [3:0] talker_lookup(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] ab;
      logic [3:0]  t;
      ab = {a, b};
      case (ab)
         16'h4750: t = TALK_GP;
         16'h474E: t = TALK_GN;
         16'h474C: t = TALK_GL;
         16'h4741: t = TALK_GA;
         16'h4742: t = TALK_GB;
         16'h4244: t = TALK_BD;
         16'h4751: t = TALK_GQ;
         16'h494E: t = TALK_IN;
         default:  t = TALK_NONE;
      endcase
      return t;
   endfunction

   // sentence kind of a three-letter type, none when not listed
   function automatic logic [2:0] kind_lookup(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
      logic [23:0] abc;
      logic [2:0]  k;
      abc = {a, b, c};
      case (abc)
         24'h474741: k = KIND_GGA;
         24'h524D43: k = KIND_RMC;
         24'h544853: k = KIND_THS;
         24'h485052: k = KIND_HPR;
         default:    k = KIND_NONE;
      endcase
      return k;
   endfunction

   // minimum field count of a kind
   function automatic logic [CNT_W-1:0] kind_need(input logic [2:0] k);
      logic [CNT_W-1:0] n;
      case (k)
         KIND_GGA: n = NEED_GGA;
         KIND_RMC: n = NEED_RMC;
         KIND_THS: n = NEED_THS;
         KIND_HPR: n = NEED_HPR;
         KIND_UNI: n = NEED_UNI;
         default:  n = '0;
      endcase
      return n;
   endfunction

endpackage

### src/nmea_sentence_checker_classifier.sv
// nmea sentence checker and classifier: byte parser with one verdict per sentence
//
// Usage: sentence bytes enter on the req stream, one byte per transaction in
// req_tdata, with req_tlast on the final byte. Leading blanks are skipped.
// '$' sentences are checked against their two-digit hex checksum and their
// talker, type and field count; "#UNIHEADINGA," sentences against their
// ';'-framed payload and field count. The transaction carrying req_tlast
// produces exactly one verdict on the rsp stream; other bytes produce none.
// Throughput: one byte per cycle while verdicts are taken. Each byte goes
// through the parser in the cycle it is accepted; the verdict lands in the
// output register, on rsp in the cycle after the last byte is accepted.
// The output register is the only buffer: while it holds a verdict that the
// receiver does not take, req_tready drops and no further byte is accepted;
// a verdict taken in the same cycle frees the register for the next one.
// Reset (synchronous, active high) returns the parser to waiting for the
// first non-blank byte and empties the output register. After each last
// byte the parser returns to that same state on its own.
module nmea_sentence_checker_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] char_byte
   input  logic        req_tlast,  // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [2:0] reject_reason, [6:3] talker_code,
                                   // [7] checksum_ok, [15:8] computed_checksum,
                                   // [21:16] field_count, [23:22] zero
   output logic [2:0]  rsp_tuser   // [2:0] sentence_kind
);

   localparam int unsigned CW = nmea_chk_pkg::CNT_W;
   localparam int unsigned OW = nmea_chk_pkg::FIELD_OUT_W;
   localparam logic [CW-1:0] CNT_MAX  = CW'(nmea_chk_pkg::FIELD_COUNT_LIMIT);
   localparam logic [CW-1:0] SHOW_MAX = CW'(nmea_chk_pkg::FIELD_SHOW_MAX);

   // parser state
   nmea_chk_pkg::phase_type phase_ff, phase_in, upd_phase;
   logic [7:0]    xor_ff, xor_in, upd_xor;
   logic [3:0]    nib_ff, nib_in, upd_nib;
   logic [2:0]    hlen_ff, hlen_in, upd_hlen;
   logic [3:0]    ppos_ff, ppos_in, upd_ppos;
   logic [CW-1:0] comma_ff, comma_in, upd_comma;
   logic          seen_ff, seen_in, upd_seen;
   logic [7:0]    hdr_ff [5];
   logic          hdr_we;

   // output register
   logic          out_vld_ff, out_vld_in;
   logic [2:0]    rsn_ff, rsn_in;
   logic [2:0]    kind_ff, kind_in;
   logic [3:0]    talk_ff, talk_in;
   logic          ok_ff, ok_in;
   logic [7:0]    sum_ff, sum_in;
   logic [OW-1:0] cnt_ff, cnt_in;

   logic          acc;
   logic          acc_last;
   logic [7:0]    ch;
   logic [4:0]    hv;
   logic          blank;
   logic [CW:0]   fields_sum;
   logic [CW-1:0] fields_n;
   logic [OW-1:0] fields_show;
   logic [3:0]    talk_lk;
   logic [2:0]    kind_lk;

   assign req_tready = !out_vld_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign acc_last   = acc && req_tlast;
   assign ch         = req_tdata;
   assign hv         = nmea_chk_pkg::hex_val(ch);
   assign blank      = ch inside {nmea_chk_pkg::CH_SPACE, [8'd9:8'd13]};

   // per-byte parser update
   always_comb begin
      upd_phase = phase_ff;
      upd_xor   = xor_ff;
      upd_nib   = nib_ff;
      upd_hlen  = hlen_ff;
      upd_ppos  = ppos_ff;
      upd_comma = comma_ff;
      upd_seen  = seen_ff;
      hdr_we    = 1'b0;
      case (phase_ff)
         nmea_chk_pkg::PH_WAIT: begin
            if (!blank) begin
               if (ch == nmea_chk_pkg::CH_DOLLAR) begin
                  upd_phase = nmea_chk_pkg::PH_D_HEAD;
               end else if (ch == nmea_chk_pkg::CH_HASH) begin
                  upd_phase = nmea_chk_pkg::PH_U_PREFIX;
                  upd_ppos  = 4'd1;
               end else begin
                  upd_phase = nmea_chk_pkg::PH_FRAME;
               end
            end
         end
         nmea_chk_pkg::PH_D_HEAD, nmea_chk_pkg::PH_D_BODY: begin
            if (ch == nmea_chk_pkg::CH_STAR) begin
               upd_phase = nmea_chk_pkg::PH_D_HEX1;
            end else begin
               upd_xor  = xor_ff ^ ch;
               upd_seen = 1'b1;
               if (ch == nmea_chk_pkg::CH_COMMA) begin
                  if (comma_ff < CNT_MAX) upd_comma = comma_ff + 1'b1;
                  upd_phase = nmea_chk_pkg::PH_D_BODY;
               end else if (phase_ff == nmea_chk_pkg::PH_D_HEAD) begin
                  hdr_we = (hlen_ff < 3'd5);
                  if (hlen_ff < 3'd6) upd_hlen = hlen_ff + 1'b1;
               end
            end
         end
         nmea_chk_pkg::PH_D_HEX1: begin
            if (hv[4]) begin
               upd_phase = nmea_chk_pkg::PH_D_BADHEX;
            end else begin
               upd_nib   = hv[3:0];
               upd_phase = nmea_chk_pkg::PH_D_HEX2;
            end
         end
         nmea_chk_pkg::PH_D_HEX2: begin
            if (hv[4]) upd_phase = nmea_chk_pkg::PH_D_BADHEX;
            else if ({nib_ff, hv[3:0]} == xor_ff) upd_phase = nmea_chk_pkg::PH_D_OK;
            else upd_phase = nmea_chk_pkg::PH_D_BADSUM;
         end
         nmea_chk_pkg::PH_U_PREFIX: begin
            if (ppos_ff < nmea_chk_pkg::UNI_PREFIX_LEN &&
                ch == nmea_chk_pkg::uni_prefix_char(ppos_ff)) begin
               upd_ppos = ppos_ff + 1'b1;
               if (upd_ppos == nmea_chk_pkg::UNI_PREFIX_LEN) upd_phase = nmea_chk_pkg::PH_U_SEMI;
            end else begin
               upd_phase = nmea_chk_pkg::PH_U_BADPFX;
            end
         end
         nmea_chk_pkg::PH_U_SEMI: begin
            if (ch == nmea_chk_pkg::CH_SEMI) upd_phase = nmea_chk_pkg::PH_U_PAY;
         end
         nmea_chk_pkg::PH_U_PAY: begin
            if (ch == nmea_chk_pkg::CH_STAR) begin
               upd_phase = seen_ff ? nmea_chk_pkg::PH_U_DONE : nmea_chk_pkg::PH_FRAME;
            end else begin
               upd_seen = 1'b1;
               if (ch == nmea_chk_pkg::CH_COMMA && comma_ff < CNT_MAX)
                  upd_comma = comma_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // fields seen so far, saturating
   assign fields_sum = {1'b0, upd_comma} + 1'b1;
   always_comb begin
      if (!upd_seen) fields_n = '0;
      else if (fields_sum > {1'b0, CNT_MAX}) fields_n = CNT_MAX;
      else fields_n = fields_sum[CW-1:0];
   end

   // reported field count, clipped to the output width
   assign fields_show = (fields_n > SHOW_MAX) ? OW'(SHOW_MAX) : OW'(fields_n);

   // header lookups, read only once all five entries are written
   assign talk_lk = nmea_chk_pkg::talker_lookup(hdr_ff[0], hdr_ff[1]);
   assign kind_lk = nmea_chk_pkg::kind_lookup(hdr_ff[2], hdr_ff[3], hdr_ff[4]);

   // verdict from the state after the last byte
   always_comb begin
      rsn_in  = nmea_chk_pkg::RSN_FRAME;
      kind_in = nmea_chk_pkg::KIND_NONE;
      talk_in = nmea_chk_pkg::TALK_NONE;
      ok_in   = 1'b0;
      sum_in  = 8'd0;
      cnt_in  = '0;
      case (upd_phase)
         nmea_chk_pkg::PH_D_HEAD, nmea_chk_pkg::PH_D_BODY, nmea_chk_pkg::PH_D_HEX1,
         nmea_chk_pkg::PH_D_HEX2, nmea_chk_pkg::PH_D_BADHEX: begin
            sum_in = upd_xor;
         end
         nmea_chk_pkg::PH_D_BADSUM: begin
            rsn_in = nmea_chk_pkg::RSN_CHECKSUM;
            sum_in = upd_xor;
         end
         nmea_chk_pkg::PH_D_OK: begin
            ok_in  = 1'b1;
            sum_in = upd_xor;
            cnt_in = fields_show;
            rsn_in = nmea_chk_pkg::RSN_HEADER;
            if (upd_seen && upd_hlen >= 3'd5) begin
               talk_in = talk_lk;
               if (talk_lk == nmea_chk_pkg::TALK_NONE) begin
                  rsn_in = nmea_chk_pkg::RSN_TALKER;
               end else if (upd_hlen == 3'd5 && kind_lk != nmea_chk_pkg::KIND_NONE) begin
                  kind_in = kind_lk;
                  rsn_in  = (fields_n < nmea_chk_pkg::kind_need(kind_lk)) ?
                            nmea_chk_pkg::RSN_FIELDS : nmea_chk_pkg::RSN_OK;
               end
            end
         end
         nmea_chk_pkg::PH_U_SEMI, nmea_chk_pkg::PH_U_PAY: begin
            kind_in = nmea_chk_pkg::KIND_UNI;
            talk_in = nmea_chk_pkg::TALK_UN;
         end
         nmea_chk_pkg::PH_U_DONE: begin
            kind_in = nmea_chk_pkg::KIND_UNI;
            talk_in = nmea_chk_pkg::TALK_UN;
            cnt_in  = fields_show;
            rsn_in  = (fields_n < nmea_chk_pkg::NEED_UNI) ?
                      nmea_chk_pkg::RSN_FIELDS : nmea_chk_pkg::RSN_OK;
         end
         nmea_chk_pkg::PH_U_BADPFX: begin
            rsn_in = nmea_chk_pkg::RSN_HEADER;
         end
         default: begin
         end
      endcase
   end

   // next state: back to waiting after a last byte
   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      nib_in   = nib_ff;
      hlen_in  = hlen_ff;
      ppos_in  = ppos_ff;
      comma_in = comma_ff;
      seen_in  = seen_ff;
      if (acc_last) begin
         phase_in = nmea_chk_pkg::PH_WAIT;
         xor_in   = 8'd0;
         nib_in   = 4'd0;
         hlen_in  = 3'd0;
         ppos_in  = 4'd0;
         comma_in = '0;
         seen_in  = 1'b0;
      end else if (acc) begin
         phase_in = upd_phase;
         xor_in   = upd_xor;
         nib_in   = upd_nib;
         hlen_in  = upd_hlen;
         ppos_in  = upd_ppos;
         comma_in = upd_comma;
         seen_in  = upd_seen;
      end
   end

   // output valid: set by a verdict, cleared when taken
   always_comb begin
      out_vld_in = out_vld_ff;
      if (acc_last) out_vld_in = 1'b1;
      else if (rsp_tready) out_vld_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nmea_chk_pkg::PH_WAIT;
         xor_ff     <= 8'd0;
         nib_ff     <= 4'd0;
         hlen_ff    <= 3'd0;
         ppos_ff    <= 4'd0;
         comma_ff   <= '0;
         seen_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         xor_ff     <= xor_in;
         nib_ff     <= nib_in;
         hlen_ff    <= hlen_in;
         ppos_ff    <= ppos_in;
         comma_ff   <= comma_in;
         seen_ff    <= seen_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // header character store, no reset
   always_ff @(posedge clock) begin
      if (acc && hdr_we) hdr_ff[hlen_ff] <= ch;
   end

   // verdict payload register
   always_ff @(posedge clock) begin
      if (acc_last) begin
         rsn_ff  <= rsn_in;
         kind_ff <= kind_in;
         talk_ff <= talk_in;
         ok_ff   <= ok_in;
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result stream
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, cnt_ff, sum_ff, ok_ff, talk_ff, rsn_ff};
   assign rsp_tuser  = kind_ff;

   // a last byte always yields a verdict on the next cycle
   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      acc_last |=> rsp_tvalid)
      else $error("no verdict after last byte");

   // the parser restarts after every last byte
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      acc_last |=> (phase_ff == nmea_chk_pkg::PH_WAIT) && (comma_ff == '0) && !seen_ff)
      else $error("parser state not cleared after last byte");

   // an accepted dollar sentence must have passed its checksum
   a_accept_needs_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsn_ff == nmea_chk_pkg::RSN_OK) && (kind_ff != nmea_chk_pkg::KIND_UNI)
      |-> ok_ff)
      else $error("dollar sentence accepted without checksum match");

   // unicore kind and talker always go together
   a_uni_pairing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((kind_ff == nmea_chk_pkg::KIND_UNI) == (talk_ff == nmea_chk_pkg::TALK_UN)))
      else $error("unicore kind and talker disagree");

   // a held verdict stalls the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("byte accepted while verdict stalled");

endmodule
